### design/utf8d_pkg.sv
`timescale 1ns / 1ps
package utf8d_pkg;

    // error report codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_START = 3'd1,
        ERR_BAD_CONT  = 3'd2,
        ERR_OVERLONG  = 3'd3,
        ERR_SURROGATE = 3'd4,
        ERR_RANGE     = 3'd5,
        ERR_TRUNCATED = 3'd6
    } err_code_t;

    localparam int unsigned CP_W = 21;

    // sequence widths
    localparam logic [2:0] SEQ_W2 = 3'd2;
    localparam logic [2:0] SEQ_W3 = 3'd3;
    localparam logic [2:0] SEQ_W4 = 3'd4;

    // value limits
    localparam logic [CP_W-1:0] MIN_W2    = 21'h00080;
    localparam logic [CP_W-1:0] MIN_W3    = 21'h00800;
    localparam logic [CP_W-1:0] MIN_W4    = 21'h10000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } byte_item_t;

    // one result beat
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            good;
        err_code_t       error_code;
        logic            last_item;
        logic            buffer_valid;
    } result_t;

endpackage

### design/utf8d_in_stage.sv
`timescale 1ns / 1ps
module utf8d_in_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  utf8d_pkg::byte_item_t  item_in,
    input  logic                   advance_ok,
    output logic                   item_valid,
    output utf8d_pkg::byte_item_t  item_out
);
    import utf8d_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       load;

    // hold a beat until the decoder can take it
    assign byte_stall = valid_reg && !advance_ok;
    assign load       = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance_ok)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

### design/utf8d_decode.sv
`timescale 1ns / 1ps
module utf8d_decode
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  utf8d_pkg::byte_item_t  item,
    output logic                   emit,
    output utf8d_pkg::result_t     result
);
    import utf8d_pkg::*;

    logic [1:0]      bytes_remaining_reg;
    logic [1:0]      bytes_remaining_next;
    logic [2:0]      sequence_width_reg;
    logic [2:0]      sequence_width_next;
    logic [CP_W-1:0] partial_value_reg;
    logic [CP_W-1:0] partial_value_next;
    logic            error_seen_reg;
    logic            error_seen_next;

    logic [7:0]      b;
    logic            last;
    logic [CP_W-1:0] cp;
    err_code_t       err;
    err_code_t       chk;
    logic [CP_W-1:0] gathered;
    logic [1:0]      rem_dec;
    logic            any_err;

    assign b        = item.byte_val;
    assign last     = item.last;
    assign gathered = {partial_value_reg[CP_W-7:0], b[5:0]};
    assign rem_dec  = bytes_remaining_reg - 2'd1;

    // range checks on a finished sequence
    always_comb
    begin
        chk = ERR_NONE;
        case (sequence_width_reg)
            SEQ_W2:
            begin
                if (gathered < MIN_W2)
                begin
                    chk = ERR_OVERLONG;
                end
            end
            SEQ_W3:
            begin
                if (gathered < MIN_W3)
                begin
                    chk = ERR_OVERLONG;
                end
                else if (gathered >= SURR_LO && gathered <= SURR_HI)
                begin
                    chk = ERR_SURROGATE;
                end
            end
            default:
            begin
                if (gathered < MIN_W4)
                begin
                    chk = ERR_OVERLONG;
                end
                else if (gathered > CP_MAX)
                begin
                    chk = ERR_RANGE;
                end
            end
        endcase
    end

    // byte decode and next state
    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        sequence_width_next  = sequence_width_reg;
        partial_value_next   = partial_value_reg;
        error_seen_next      = error_seen_reg;
        emit                 = 1'b0;
        cp                   = '0;
        err                  = ERR_NONE;

        if (bytes_remaining_reg == 2'd0)
        begin
            // start byte
            if (b[7] == 1'b0)
            begin
                emit = 1'b1;
                cp   = {{(CP_W-8){1'b0}}, b};
            end
            else if (b inside {[8'h80:8'hBF], [8'hF8:8'hFF]})
            begin
                emit = 1'b1;
                err  = ERR_BAD_START;
            end
            else if (last)
            begin
                emit = 1'b1;
                err  = ERR_TRUNCATED;
            end
            else if (b < 8'hE0)
            begin
                sequence_width_next  = SEQ_W2;
                partial_value_next   = {{(CP_W-5){1'b0}}, b[4:0]};
                bytes_remaining_next = 2'd1;
            end
            else if (b < 8'hF0)
            begin
                sequence_width_next  = SEQ_W3;
                partial_value_next   = {{(CP_W-4){1'b0}}, b[3:0]};
                bytes_remaining_next = 2'd2;
            end
            else
            begin
                sequence_width_next  = SEQ_W4;
                partial_value_next   = {{(CP_W-3){1'b0}}, b[2:0]};
                bytes_remaining_next = 2'd3;
            end
        end
        else
        begin
            // continuation byte
            if (b[7:6] != 2'b10)
            begin
                emit = 1'b1;
                err  = ERR_BAD_CONT;
            end
            else if (rem_dec == 2'd0)
            begin
                emit                 = 1'b1;
                cp                   = gathered;
                err                  = chk;
                bytes_remaining_next = 2'd0;
                sequence_width_next  = 3'd0;
                partial_value_next   = '0;
            end
            else if (last)
            begin
                emit = 1'b1;
                err  = ERR_TRUNCATED;
            end
            else
            begin
                partial_value_next   = gathered;
                bytes_remaining_next = rem_dec;
            end
        end

        any_err = (err != ERR_NONE);

        // drop partial sequence on error or buffer end
        if (emit)
        begin
            if (any_err || last)
            begin
                bytes_remaining_next = 2'd0;
                sequence_width_next  = 3'd0;
                partial_value_next   = '0;
            end
            error_seen_next = last ? 1'b0 : (error_seen_reg || any_err);
        end

        result.code_point   = any_err ? '0 : cp;
        result.good         = !any_err;
        result.error_code   = err;
        result.last_item    = last;
        result.buffer_valid = last && !(error_seen_reg || any_err);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= 2'd0;
            sequence_width_reg  <= 3'd0;
            partial_value_reg   <= '0;
            error_seen_reg      <= 1'b0;
        end
        else if (fire)
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            sequence_width_reg  <= sequence_width_next;
            partial_value_reg   <= partial_value_next;
            error_seen_reg      <= error_seen_next;
        end
    end

endmodule

### design/utf8d_out_stage.sv
`timescale 1ns / 1ps
module utf8d_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  utf8d_pkg::result_t  result_in,
    output logic                slot_free,
    output logic                result_valid,
    input  logic                result_stall,
    output utf8d_pkg::result_t  result_out
);
    import utf8d_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // slot is free when empty or when the held beat leaves this cycle
    assign slot_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (slot_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

endmodule

### design/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// path: an accepted byte is held in the input register, decoded, then loaded into the result register
// throughput: one byte per cycle while result_stall is low; the input register and the result register
//   advance together whenever the result register is empty or being drained
// bytes that leave a sequence open give no result beat
// reset: asynchronous, active low; clears both valid flags and the decoder state
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_point,
    output logic        good,
    output logic [2:0]  error_code,
    output logic        last_item,
    output logic        buffer_valid
);
    import utf8d_pkg::*;

    byte_item_t item_in;
    byte_item_t item_q;
    logic       item_valid;
    logic       slot_free;
    logic       fire;
    logic       emit;
    result_t    dec_result;
    result_t    out_result;

    assign item_in.byte_val = byte_in;
    assign item_in.last     = last_byte;

    // input register
    utf8d_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .item_in    (item_in),
        .advance_ok (slot_free),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    assign fire = item_valid && slot_free;

    // decoder state and byte logic
    utf8d_decode u_dec
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_q),
        .emit   (emit),
        .result (dec_result)
    );

    // result register
    utf8d_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && emit),
        .result_in    (dec_result),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_out   (out_result)
    );

    assign code_point   = out_result.code_point;
    assign good         = out_result.good;
    assign error_code   = out_result.error_code;
    assign last_item    = out_result.last_item;
    assign buffer_valid = out_result.buffer_valid;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import utf8d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  byte_in;
    logic        last_byte;
    logic        result_valid;
    logic        result_stall;
    logic [20:0] code_point;
    logic        good;
    logic [2:0]  error_code;
    logic        last_item;
    logic        buffer_valid;

    // decoder state as the block should hold it
    logic [1:0]  dec_left;
    logic [2:0]  dec_width;
    logic [20:0] dec_acc;
    logic        dec_err_seen;

    result_t     pending_results[$];
    result_t     due;
    byte_q_t     text_bytes;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_request;
    int unsigned rx_hold_left;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned buffers_sent;
    int unsigned beats_checked;
    int unsigned error_hits[8];

    utf8_stream_decoder uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_in      (byte_in),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .good         (good),
        .error_code   (error_code),
        .last_item    (last_item),
        .buffer_valid (buffer_valid)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // queue one expected result beat and apply the end-of-sequence bookkeeping
    function automatic void post_result(input logic [20:0] cp, input err_code_t err,
                                        input logic is_last);
        result_t r;
        if (err != ERR_NONE)
            dec_err_seen = 1'b1;
        r.code_point   = (err != ERR_NONE) ? '0 : cp;
        r.good         = (err == ERR_NONE);
        r.error_code   = err;
        r.last_item    = is_last;
        r.buffer_valid = is_last && !dec_err_seen;
        pending_results.push_back(r);
        if (err != ERR_NONE || is_last)
        begin
            dec_left  = '0;
            dec_width = '0;
            dec_acc   = '0;
        end
        if (is_last)
            dec_err_seen = 1'b0;
    endfunction

    // advance the decoder by one accepted byte
    function automatic void decode_byte(input logic [7:0] b, input logic is_last);
        logic [20:0] v;
        err_code_t   err;
        if (dec_left == 2'd0)
        begin
            if (b < 8'h80)
                post_result({13'd0, b}, ERR_NONE, is_last);
            else if (b < 8'hC0 || b >= 8'hF8)
                post_result('0, ERR_BAD_START, is_last);
            else if (is_last)
                post_result('0, ERR_TRUNCATED, 1'b1);
            else
            begin
                if (b < 8'hE0)
                begin
                    dec_width = SEQ_W2;
                    dec_acc   = {16'd0, b[4:0]};
                end
                else if (b < 8'hF0)
                begin
                    dec_width = SEQ_W3;
                    dec_acc   = {17'd0, b[3:0]};
                end
                else
                begin
                    dec_width = SEQ_W4;
                    dec_acc   = {18'd0, b[2:0]};
                end
                dec_left = 2'(dec_width - 3'd1);
            end
        end
        else if (b[7:6] != 2'b10)
            post_result('0, ERR_BAD_CONT, is_last);
        else
        begin
            dec_acc  = {dec_acc[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0)
            begin
                // sequence complete: range checks by width
                v   = dec_acc;
                err = ERR_NONE;
                case (dec_width)
                    SEQ_W2:
                    begin
                        if (v < MIN_W2)
                            err = ERR_OVERLONG;
                    end
                    SEQ_W3:
                    begin
                        if (v < MIN_W3)
                            err = ERR_OVERLONG;
                        else if (v >= SURR_LO && v <= SURR_HI)
                            err = ERR_SURROGATE;
                    end
                    default:
                    begin
                        if (v < MIN_W4)
                            err = ERR_OVERLONG;
                        else if (v > CP_MAX)
                            err = ERR_RANGE;
                    end
                endcase
                dec_width = '0;
                dec_acc   = '0;
                post_result(v, err, is_last);
            end
            else if (is_last)
                post_result('0, ERR_TRUNCATED, 1'b1);
        end
    endfunction

    // offer one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            byte_in    <= 8'($urandom);
            last_byte  <= 1'($urandom);
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_in    <= b;
        last_byte  <= is_last;
        do
            @(posedge clk);
        while (byte_stall);
        decode_byte(b, is_last);
        bytes_sent++;
        if (is_last)
            buffers_sent++;
    endtask

    // send a run of bytes, optionally closing the buffer on the final one
    task automatic send_bytes(input byte_q_t q, input logic close_buf);
        foreach (q[i])
            send_byte(q[i], close_buf && (i == q.size() - 1));
    endtask

    // stop offering, wait for every expected beat, then let the pipeline settle
    task automatic drain();
        int unsigned waited;
        waited = 0;
        byte_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // append one character: mostly well-formed, some malformed, some noise or cut short
    function automatic void add_char();
        int unsigned kind;
        int unsigned n;
        int unsigned keep;
        logic [20:0] cp;
        logic [7:0]  seq[4];
        kind = $urandom_range(99);
        if (kind >= 85 && kind < 93)
        begin
            text_bytes.push_back(8'($urandom));
            return;
        end
        if (kind < 60)
        begin
            n = $urandom_range(4, 1);
            case (n)
                1: cp = 21'($urandom_range(8'h7F));
                2: cp = 21'($urandom_range(12'h7FF, 8'h80));
                3:
                begin
                    do
                        cp = 21'($urandom_range(16'hFFFF, 12'h800));
                    while (cp >= SURR_LO && cp <= SURR_HI);
                end
                default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            endcase
        end
        else
        begin
            // any payload the width can carry: overlong, surrogate and range cases
            n  = $urandom_range(4, 2);
            cp = 21'($urandom) & ((21'd1 << (5 * n + 1)) - 21'd1);
        end
        case (n)
            1: seq[0] = cp[7:0];
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        keep = n;
        if (kind >= 93 && n > 1)
            keep = $urandom_range(n - 1, 1);
        for (int i = 0; i < keep; i++)
            text_bytes.push_back(seq[i]);
    endfunction

    // extremes, each error kind, truncation and buffer flag
    task automatic test_directed();
        // clean buffer: ascii, width boundaries, largest scalar
        send_bytes('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
        // overlong 2/3/4, surrogate, above range
        send_bytes('{8'hC0, 8'h80, 8'hE0, 8'h80, 8'h80, 8'hF0, 8'h80, 8'h80, 8'h80,
                     8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
        // bad starts, bad continuation, then cut short at buffer end
        send_bytes('{8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC2, 8'h41, 8'hE2, 8'h82}, 1'b1);
        // bad continuation on the closing byte wins over truncation
        send_bytes('{8'hE2, 8'h41}, 1'b1);
        // lead byte alone closing the buffer
        send_bytes('{8'hF0}, 1'b1);
        drain();
    endtask

    // random buffers of mixed characters
    task automatic test_random(input int unsigned target);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            text_bytes.delete();
            repeat ($urandom_range(12, 1))
                add_char();
            send_bytes(text_bytes, 1'b1);
        end
        drain();
    endtask

    // long receiver hold-off while ascii keeps coming, so the input backs up
    task automatic test_backpressure();
        text_bytes.delete();
        repeat (60)
            text_bytes.push_back(8'($urandom_range(8'h7F)));
        rx_hold_request = 200;
        send_bytes(text_bytes, 1'b1);
        drain();
    endtask

    // result side stall: long hold when requested, otherwise random
    always @(posedge clk)
    begin
        if (rx_hold_request != 0)
        begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0)
        begin
            result_stall <= 1'b1;
            rx_hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic void check_field(input string name, input logic [20:0] want,
                                        input logic [20:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: code_point 0x%0h error_code %0d",
                       code_point, error_code);
                mismatches++;
            end
            else
            begin
                due = pending_results.pop_front();
                check_field("code_point", due.code_point, code_point);
                check_field("good", 21'(due.good), 21'(good));
                check_field("error_code", 21'(due.error_code), 21'(error_code));
                check_field("last_item", 21'(due.last_item), 21'(last_item));
                check_field("buffer_valid", 21'(due.buffer_valid), 21'(buffer_valid));
                error_hits[due.error_code]++;
                beats_checked++;
            end
        end
    end

    initial
    begin
        dec_left        = '0;
        dec_width       = '0;
        dec_acc         = '0;
        dec_err_seen    = 1'b0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 0;
        rx_hold_left    = 0;
        cycle_count     = 0;
        mismatches      = 0;
        bytes_sent      = 0;
        buffers_sent    = 0;
        beats_checked   = 0;
        foreach (error_hits[i])
            error_hits[i] = 0;
        rst_n        <= 1'b0;
        byte_valid   <= 1'b0;
        byte_in      <= 8'h00;
        last_byte    <= 1'b0;
        result_stall <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        tx_idle_pct = 17;
        rx_idle_pct = 58;
        test_random(500);
        tx_idle_pct = 58;
        rx_idle_pct = 17;
        test_random(500);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random(500);

        drain();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("decoded %0d bytes in %0d buffers, %0d result beats compared",
                 bytes_sent, buffers_sent, beats_checked);
        $display(
            "by kind: ok %0d, start %0d, cont %0d, overlong %0d, surr %0d, range %0d, cut %0d",
                 error_hits[ERR_NONE], error_hits[ERR_BAD_START], error_hits[ERR_BAD_CONT],
                 error_hits[ERR_OVERLONG], error_hits[ERR_SURROGATE], error_hits[ERR_RANGE],
                 error_hits[ERR_TRUNCATED]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
design/utf8d_pkg.sv
design/utf8d_in_stage.sv
design/utf8d_decode.sv
design/utf8d_out_stage.sv
design/utf8_stream_decoder.sv
tb/sv/testbench.sv
